// ----- src/bcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcmp_pkg
// Types, constants and helpers shared by the barometer compensation core.
// ----------------------------------------------------------------------------
package bcmp_pkg;

  localparam int unsigned OversamplingDefault = 0;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW = 32;
  localparam int unsigned DivSteps = 32;

  localparam logic [RegIdxW-1:0] REG_AC1   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_AC2   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_AC3   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_AC4   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_AC5   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_AC6   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_B1_B2 = 3'd6;
  localparam logic [RegIdxW-1:0] REG_MC_MD = 3'd7;

  localparam logic signed [31:0] K_B6_OFS = 32'sd4000;
  localparam logic [31:0] K_HALF = 32'd32768;
  localparam logic [31:0] K_B7_MUL = 32'd50000;
  localparam logic signed [31:0] K_C1 = 32'sd3038;
  localparam logic signed [31:0] K_C2 = -32'sd7357;
  localparam logic signed [31:0] K_C3 = 32'sd3791;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_fault;
  } result_t;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } cal_t;

  // one restoring step on unsigned 32-bit values
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [31:0] dvsr, logic nb);
    logic [32:0] trial;
    div_state_t  r;
    trial = {s.rem, nb} - {1'b0, dvsr};
    r.quo = {s.quo[30:0], ~trial[32]};
    r.rem = trial[32] ? {s.rem[30:0], nb} : trial[31:0];
    return r;
  endfunction

endpackage

// ----- src/bcmp_udiv.sv -----
// ----------------------------------------------------------------------------
// bcmp_udiv
// Pipelined unsigned 32/32 divider, one quotient bit per stage, with a
// sideband that travels alongside.
// ----------------------------------------------------------------------------
module bcmp_udiv import bcmp_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [31:0]      dividend,
  input  logic [31:0]      divisor,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [31:0]      quotient,
  output logic [SideW-1:0] out_side
);

  logic [DivSteps:0]      vld;
  div_state_t             st   [DivSteps+1];
  logic [31:0]            dvd  [DivSteps+1];
  logic [31:0]            dvs  [DivSteps+1];
  logic [SideW-1:0]       side [DivSteps+1];

  assign vld[0]  = in_valid;
  assign st[0]   = '0;
  assign dvd[0]  = dividend;
  assign dvs[0]  = divisor;
  assign side[0] = in_side;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      st[i+1]   <= div_step(st[i], dvs[i], dvd[i][31-i]);
      dvd[i+1]  <= dvd[i];
      dvs[i+1]  <= dvs[i];
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[DivSteps];
  assign quotient  = st[DivSteps].quo;
  assign out_side  = side[DivSteps];

endmodule

// ----- src/bcmp_cal_regs.sv -----
// ----------------------------------------------------------------------------
// bcmp_cal_regs
// Calibration register file, written through the plain write port.
// ----------------------------------------------------------------------------
module bcmp_cal_regs import bcmp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cal_t               cal
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AC1:   cal.ac1 <= cfg_data[15:0];
        REG_AC2:   cal.ac2 <= cfg_data[15:0];
        REG_AC3:   cal.ac3 <= cfg_data[15:0];
        REG_AC4:   cal.ac4 <= cfg_data[15:0];
        REG_AC5:   cal.ac5 <= cfg_data[15:0];
        REG_AC6:   cal.ac6 <= cfg_data[15:0];
        REG_B1_B2: begin
          cal.b1 <= cfg_data[31:16];
          cal.b2 <= cfg_data[15:0];
        end
        REG_MC_MD: begin
          cal.mc <= cfg_data[31:16];
          cal.md <= cfg_data[15:0];
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/barometer_compensation_core.sv -----
// ----------------------------------------------------------------------------
// barometer_compensation_core
// Pipeline: two 32-stage dividers and 15 math stages from start to done.
// Throughput: one sample pair per cycle; every stage is a register, no stalls.
// The receiver cannot stall: each result shows on result for one cycle with done.
// Reset: synchronous, active high; clears calibration registers and valid bits.
// ----------------------------------------------------------------------------
module barometer_compensation_core import bcmp_pkg::*; #(
  parameter int unsigned OVERSAMPLING = OversamplingDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sample_t            sample,
  output logic               done,
  output result_t            result,
  input  logic               cfg_write,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  localparam int unsigned Oss = OVERSAMPLING & 3;
  localparam logic [31:0] B7Mul = K_B7_MUL >> Oss;

  typedef struct packed {
    logic               fault;
    logic signed [31:0] temp;
    logic signed [31:0] b5;
    logic [18:0]        up;
  } tside_t;

  cal_t cal;
  assign busy = 1'b0;

  bcmp_cal_regs u_regs (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .cal
  );

  // ---------------- temperature front end ----------------
  logic               v1, v2, v3;
  logic signed [31:0] t1_diff, t2_prod, t3_x1;
  logic [18:0]        up1, up2, up3;
  logic [31:0]        t3_num;
  logic signed [31:0] t3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else begin
      v1 <= start; v2 <= v1; v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t1_diff <= $signed({16'd0, sample.raw_temperature}) - $signed({16'd0, cal.ac6});
    up1     <= sample.raw_pressure;
    t2_prod <= t1_diff * $signed({16'd0, cal.ac5});
    up2     <= up1;
    t3_x1   <= t2_prod >>> 15;
    t3_den  <= (t2_prod >>> 15) + 32'(cal.md);
    t3_num  <= 32'(cal.mc) << 11;
    up3     <= up2;
  end

  // signed divide through unsigned core
  logic        td_fault, tq_neg;
  logic [31:0] td_a, td_b;
  assign td_fault = (t3_den == 0);
  assign tq_neg   = t3_num[31] ^ t3_den[31];
  assign td_a     = t3_num[31] ? -t3_num : t3_num;
  assign td_b     = td_fault ? 32'd1 : (t3_den[31] ? -t3_den : t3_den);

  logic              tdv;
  logic [31:0]       tq;
  logic [52:0]       tds_in, tds_out;
  assign tds_in = {tq_neg, td_fault, t3_x1, up3};

  bcmp_udiv #(.SideW(53)) u_tdiv (
    .clk, .rst, .in_valid(v3), .dividend(td_a), .divisor(td_b),
    .in_side(tds_in), .out_valid(tdv), .quotient(tq), .out_side(tds_out)
  );

  // ---------------- pressure coefficient stages ----------------
  logic               p1v, p2v, p3v, p4v, p5v, p6v, p7v;
  tside_t             s1, s2, s3, s4, s5, s6, s7;
  logic signed [31:0] b6_2, sq3, b6_3;
  logic signed [31:0] m_b2sq, m_ac2b6, m_ac3b6, m_b1sq;
  logic signed [31:0] b3_5, x3_5;
  logic [31:0]        b4_6, b7_6, b4_7, num_7;
  logic               b7hi_7;
  logic signed [31:0] b5_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      {p1v, p2v, p3v, p4v, p5v, p6v, p7v} <= '0;
    end else begin
      p1v <= tdv; p2v <= p1v; p3v <= p2v; p4v <= p3v;
      p5v <= p4v; p6v <= p5v; p7v <= p6v;
    end
  end

  always_ff @(posedge clk) begin
    b5_1    <= $signed(tds_out[50:19]) + (tds_out[52] ? -$signed(tq) : $signed(tq));
    s1.fault <= tds_out[51];
    s1.up   <= tds_out[18:0];
    s1.temp <= '0;
    s1.b5   <= '0;
    // stage 2
    s2       <= '{fault: s1.fault, temp: (b5_1 + 32'sd8) >>> 4, b5: b5_1, up: s1.up};
    b6_2     <= b5_1 - K_B6_OFS;
    // stage 3
    s3       <= s2;
    b6_3     <= b6_2;
    sq3      <= (b6_2 * b6_2) >>> 12;
    // stage 4
    s4       <= s3;
    m_b2sq   <= 32'(cal.b2) * sq3;
    m_ac2b6  <= 32'(cal.ac2) * b6_3;
    m_ac3b6  <= 32'(cal.ac3) * b6_3;
    m_b1sq   <= 32'(cal.b1) * sq3;
    // stage 5
    s5       <= s4;
    b3_5     <= ((((32'(cal.ac1) <<< 2) + (m_b2sq >>> 11) + (m_ac2b6 >>> 11)) <<< Oss)
                 + 32'sd2) >>> 2;
    x3_5     <= ((m_ac3b6 >>> 13) + (m_b1sq >>> 16) + 32'sd2) >>> 2;
    // stage 6
    s6       <= s5;
    b4_6     <= 32'({16'd0, cal.ac4} * ($unsigned(x3_5) + K_HALF)) >> 15;
    b7_6     <= ({13'd0, s5.up} - $unsigned(b3_5)) * B7Mul;
    // stage 7
    s7       <= '{fault: s6.fault | (b4_6 == 0), temp: s6.temp, b5: s6.b5, up: s6.up};
    b4_7     <= (b4_6 == 0) ? 32'd1 : b4_6;
    b7hi_7   <= b7_6[31];
    num_7    <= b7_6[31] ? b7_6 : {b7_6[30:0], 1'b0};
  end

  logic              pdv;
  logic [31:0]       pq;
  logic [33:0]       pds_out;

  bcmp_udiv #(.SideW(34)) u_pdiv (
    .clk, .rst, .in_valid(p7v), .dividend(num_7), .divisor(b4_7),
    .in_side({b7hi_7, s7.fault, s7.temp}), .out_valid(pdv), .quotient(pq),
    .out_side(pds_out)
  );

  // ---------------- pressure polish ----------------
  logic               q1v, q2v, q3v, q4v;
  logic signed [31:0] pr1, pr2, pr3, sq_q2, x1_q3, x2_q3, pr4;
  logic signed [31:0] t_q1, t_q2, t_q3, t_q4;
  logic               f_q1, f_q2, f_q3, f_q4;

  always_ff @(posedge clk) begin
    if (rst) begin
      {q1v, q2v, q3v, q4v, done} <= '0;
    end else begin
      q1v <= pdv; q2v <= q1v; q3v <= q2v; q4v <= q3v; done <= q4v;
    end
  end

  always_ff @(posedge clk) begin
    pr1   <= pds_out[33] ? $signed({pq[30:0], 1'b0}) : $signed(pq);
    f_q1  <= pds_out[32];
    t_q1  <= pds_out[31:0];
    sq_q2 <= (pr1 >>> 8) * (pr1 >>> 8);
    x2_q3 <= (K_C2 * pr2) >>> 16;
    pr2   <= pr1; f_q2 <= f_q1; t_q2 <= t_q1;
    x1_q3 <= (sq_q2 * K_C1) >>> 16;
    pr3   <= pr2; f_q3 <= f_q2; t_q3 <= t_q2;
    pr4   <= pr3 + ((x1_q3 + x2_q3 + K_C3) >>> 4);
    f_q4  <= f_q3; t_q4 <= t_q3;
    result.divide_fault       <= f_q4;
    result.temperature_tenths <= f_q4 ? '0 : t_q4;
    result.pressure_pa        <= f_q4 ? '0 : pr4;
  end

  unused_chk: assert property (@(posedge clk) disable iff (rst) busy == 1'b0)
    else $error("busy raised");
  lat_chk: assert property (@(posedge clk) disable iff (rst) done |-> $past(q4v))
    else $error("done without pipeline valid");
  flt_chk: assert property (@(posedge clk) disable iff (rst)
    done && result.divide_fault |-> result.pressure_pa == 0 &&
    result.temperature_tenths == 0)
    else $error("fault with nonzero result");

endmodule
